// ===== sv/full_search_block_motion_estimator_top_assert.svh =====
// Assertion macros for the motion estimator top level.
`ifndef FULL_SEARCH_BLOCK_MOTION_ESTIMATOR_TOP_ASSERT_SVH
`define FULL_SEARCH_BLOCK_MOTION_ESTIMATOR_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FSME_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FSME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/fsme_pkg.sv =====
// Shared types and constants for the motion estimator.
package fsme_pkg;
   localparam logic [1:0] CMD_LOAD_CUR = 2'd0;
   localparam logic [1:0] CMD_LOAD_REF = 2'd1;
   localparam logic [1:0] CMD_SEARCH   = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_BLOCK = 2'd2;
   localparam logic [1:0] REG_RANGE = 2'd3;

   localparam logic [21:0] SAD_MAX = 22'h3FFFFF;

   // controller to datapath commands
   typedef struct packed {
      logic start;    // latch origin, clear best, first offset
      logic new_off;  // clear sum, start next offset at pixel (0,0)
      logic px;       // issue one pixel read
      logic fin;      // compare sum of finished offset, step to next offset
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_px;  // issued pixel is last in block
      logic last_off; // current offset is last
      logic drained;  // no reads in flight
   } dp_sts_type;
endpackage

// ===== sv/fsme_datapath.sv =====
// Frame stores, address walk, SAD accumulation and best-offset tracking.
module fsme_datapath #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_RANGE = 15,
   parameter int RW = $clog2(MAX_ROWS),
   parameter int CW = $clog2(MAX_COLS)
) (
   input  logic                   clock,
   input  logic                   wr_cur,
   input  logic                   wr_ref,
   input  logic [5:0]             wr_row,
   input  logic [5:0]             wr_col,
   input  logic [23:0]            wr_pix,
   input  logic [6:0]             frame_rows,
   input  logic [6:0]             frame_cols,
   input  logic [6:0]             blk_side,
   input  logic [3:0]             srch_range,
   input  fsme_pkg::dp_cmd_type   cmd,
   output fsme_pkg::dp_sts_type   sts,
   output logic signed [4:0]      best_row,
   output logic signed [4:0]      best_col,
   output logic [21:0]            best_sad
);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = RW + CW;
   localparam int PW = 12;   // signed position width covering -63..127+63
   localparam int SW = 32;

   logic [23:0] cur_mem [DEPTH];
   logic [23:0] ref_mem [DEPTH];

   // effective config; rows, columns and range saturated
   logic [PW-1:0] rows_e, cols_e, bs_e;
   logic signed [PW-1:0] rng_e;
   always_comb begin
      rows_e = (32'(frame_rows) > 32'(MAX_ROWS)) ? PW'(MAX_ROWS) : PW'(frame_rows);
      cols_e = (32'(frame_cols) > 32'(MAX_COLS)) ? PW'(MAX_COLS) : PW'(frame_cols);
      bs_e   = PW'(blk_side);
      rng_e  = (32'(srch_range) > 32'(MAX_RANGE)) ? PW'(MAX_RANGE) : PW'(srch_range);
   end

   logic [5:0] org_row_ff, org_col_ff, org_row_in, org_col_in;
   logic signed [PW-1:0] dr_ff, dc_ff, dr_in, dc_in;
   logic [PW-1:0] x_ff, y_ff, x_in, y_in;
   logic [SW-1:0] sum_ff, sum_in, best_ff, best_in;
   logic signed [PW-1:0] bdr_ff, bdc_ff, bdr_in, bdc_in;
   logic have_ff, have_in;
   logic v1_ff, ok1_ff;
   logic [23:0] a_ff, b_ff;
   logic [9:0] d_ff;
   logic dv_ff;

   // positions of the pixel being issued
   logic signed [PW-1:0] cr, cc, rr, rc;
   logic in_frame;
   always_comb begin
      cr = $signed(PW'(org_row_ff)) + $signed(x_ff);
      cc = $signed(PW'(org_col_ff)) + $signed(y_ff);
      rr = cr + dr_ff;
      rc = cc + dc_ff;
      in_frame = (cr < $signed(rows_e)) && (rr >= 0) && (rr < $signed(rows_e)) &&
                 (cc < $signed(cols_e)) && (rc >= 0) && (rc < $signed(cols_e)) &&
                 (x_ff < bs_e) && (y_ff < bs_e);
   end

   // stores: one write and one registered read each
   logic [AW-1:0] cur_ra, ref_ra, wa;
   assign cur_ra = {cr[RW-1:0], cc[CW-1:0]};
   assign ref_ra = {rr[RW-1:0], rc[CW-1:0]};
   assign wa = {RW'(wr_row), CW'(wr_col)};
   logic wr_ok;
   assign wr_ok = (32'(wr_row) < 32'(MAX_ROWS)) && (32'(wr_col) < 32'(MAX_COLS));

   always_ff @(posedge clock) begin
      if (wr_cur && wr_ok) cur_mem[wa] <= wr_pix;
      if (wr_ref && wr_ok) ref_mem[wa] <= wr_pix;
      a_ff <= cur_mem[cur_ra];
      b_ff <= ref_mem[ref_ra];
   end

   function automatic logic [7:0] ad(input logic [7:0] p, input logic [7:0] q);
      ad = (p > q) ? p - q : q - p;
   endfunction

   // walk control
   logic last_x, last_y, last_off;
   assign last_y = (y_ff + 1'b1 >= bs_e);
   assign last_x = (x_ff + 1'b1 >= bs_e);
   assign last_off = (dr_ff == rng_e) && (dc_ff == rng_e);
   assign sts.last_px = (bs_e == '0) || (last_x && last_y);
   assign sts.last_off = last_off;
   assign sts.drained = !v1_ff && !dv_ff;

   always_comb begin
      org_row_in = org_row_ff; org_col_in = org_col_ff;
      dr_in = dr_ff; dc_in = dc_ff; x_in = x_ff; y_in = y_ff;
      sum_in = sum_ff; best_in = best_ff; bdr_in = bdr_ff; bdc_in = bdc_ff;
      have_in = have_ff;
      if (dv_ff) sum_in = sum_ff + SW'(d_ff);
      if (cmd.start) begin
         org_row_in = wr_row; org_col_in = wr_col;
         dr_in = -rng_e; dc_in = -rng_e; have_in = 1'b0;
      end
      if (cmd.fin) begin
         if (!have_ff || sum_ff < best_ff) begin
            best_in = sum_ff; bdr_in = dr_ff; bdc_in = dc_ff; have_in = 1'b1;
         end
         if (!last_off) begin
            if (dc_ff == rng_e) begin
               dc_in = -rng_e; dr_in = dr_ff + 1'b1;
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end
      end
      if (cmd.new_off || cmd.start) begin
         sum_in = '0; x_in = '0; y_in = '0;
      end else if (cmd.px) begin
         if (last_y) begin
            y_in = '0; x_in = x_ff + 1'b1;
         end else begin
            y_in = y_ff + 1'b1;
         end
      end
   end

   // read data is registered in the cycle after issue, its difference in the cycle after that
   always_ff @(posedge clock) begin
      org_row_ff <= org_row_in; org_col_ff <= org_col_in;
      dr_ff <= dr_in; dc_ff <= dc_in; x_ff <= x_in; y_ff <= y_in;
      sum_ff <= sum_in; best_ff <= best_in; bdr_ff <= bdr_in; bdc_ff <= bdc_in;
      have_ff <= have_in;
      v1_ff <= cmd.px; ok1_ff <= cmd.px && in_frame;
      dv_ff <= v1_ff && ok1_ff;
      d_ff <= 10'(ad(a_ff[23:16], b_ff[23:16])) + 10'(ad(a_ff[15:8], b_ff[15:8]))
            + 10'(ad(a_ff[7:0], b_ff[7:0]));
   end

   assign best_row = 5'(bdr_ff);
   assign best_col = 5'(bdc_ff);
   assign best_sad = (best_ff > SW'(fsme_pkg::SAD_MAX)) ? fsme_pkg::SAD_MAX : 22'(best_ff);
endmodule

// ===== sv/fsme_ctrl.sv =====
// Search sequencer: walks offsets and block pixels, issues commands to datapath.
module fsme_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic                  rsp_full,
   input  fsme_pkg::dp_sts_type  sts,
   output fsme_pkg::dp_cmd_type  cmd,
   output logic                  busy,
   output logic                  done
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PIX   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               cmd.start = 1'b1;
               state_in = ST_PIX;
            end
         end
         ST_PIX: begin
            cmd.px = 1'b1;
            if (sts.last_px) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // final compare waits until the previous result word is taken
            if (sts.drained && !(sts.last_off && rsp_full)) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            if (sts.last_off) begin
               done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.new_off = 1'b1;
               state_in = ST_PIX;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== sv/full_search_block_motion_estimator_top.sv =====
// Full-search block motion estimator: loads do not make it busy; a search holds
// the input until done, reading one pixel pair per cycle from the single-read-port
// frame stores over B*B pixels (at least one pixel slot) per offset, then draining
// the reads and doing one compare per offset (R search range, B block size, over
// (2R+1)^2 offsets); after the last compare the result word passes done_d_ff, then rsp_tvalid.
// Loads are taken while a result word waits; the last compare of the next
// search stalls until that word is read.
`include "full_search_block_motion_estimator_top_assert.svh"
module full_search_block_motion_estimator_top #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_RANGE = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // {blue, green, red, pixel_col, pixel_row} from bit 0 upward: row[5:0],
   // col[11:6], red[19:12], green[27:20], blue[35:28], zero pad to 40
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // best_row_offset[4:0], best_col_offset[9:5], best_sad[31:10]
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0] rows_ff, cols_ff, bs_ff;
   logic [3:0] rng_ff;
   logic [1:0] ridx;
   assign ridx = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd64; cols_ff <= 7'd64; bs_ff <= 7'd8; rng_ff <= 4'd7;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ridx)
            fsme_pkg::REG_ROWS:  rows_ff <= csr_pwdata[6:0];
            fsme_pkg::REG_COLS:  cols_ff <= csr_pwdata[6:0];
            fsme_pkg::REG_BLOCK: bs_ff <= csr_pwdata[6:0];
            fsme_pkg::REG_RANGE: rng_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         fsme_pkg::REG_ROWS:  csr_prdata = 32'(rows_ff);
         fsme_pkg::REG_COLS:  csr_prdata = 32'(cols_ff);
         fsme_pkg::REG_BLOCK: csr_prdata = 32'(bs_ff);
         fsme_pkg::REG_RANGE: csr_prdata = 32'(rng_ff);
         default: csr_prdata = '0;
      endcase
   end

   fsme_pkg::dp_cmd_type cmd;
   fsme_pkg::dp_sts_type sts;
   logic busy, done, acc, go;
   logic signed [4:0] brow, bcol;
   logic [21:0] bsad;

   assign req_tready = !busy;
   assign acc = req_tvalid && req_tready;
   assign go = acc && (req_tuser == fsme_pkg::CMD_SEARCH);

   fsme_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .rsp_full(rsp_tvalid), .sts(sts),
      .cmd(cmd), .busy(busy), .done(done)
   );

   fsme_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_RANGE(MAX_RANGE)) u_dp (
      .clock(clock),
      .wr_cur(acc && req_tuser == fsme_pkg::CMD_LOAD_CUR),
      .wr_ref(acc && req_tuser == fsme_pkg::CMD_LOAD_REF),
      .wr_row(req_tdata[5:0]), .wr_col(req_tdata[11:6]),
      .wr_pix({req_tdata[19:12], req_tdata[27:20], req_tdata[35:28]}),
      .frame_rows(rows_ff), .frame_cols(cols_ff), .blk_side(bs_ff),
      .srch_range(rng_ff), .cmd(cmd), .sts(sts),
      .best_row(brow), .best_col(bcol), .best_sad(bsad)
   );

   // result word register
   logic done_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0; done_d_ff <= 1'b0;
      end else begin
         done_d_ff <= done;
         if (done_d_ff) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (done_d_ff) rsp_tdata <= {bsad, bcol, brow};
   end

   `FSME_ASSERT_IMP(a_no_accept_busy, clock, reset, busy, !req_tready)
   `FSME_ASSERT_NEXT(a_done_result, clock, reset, done, !rsp_tvalid)
   `FSME_ASSERT_IMP(a_search_starts, clock, reset, go, cmd.start)
endmodule

// ===== verif/tb_top.sv =====
// Testbench for the full-search block motion estimator: loads, searches and CSR settings.
`timescale 1ns / 1ps
module tb_top;
   localparam int STORE_COLS  = 64;
   localparam int STALL_LIMIT = 100000;
   localparam int SETTLE      = 20;

   typedef struct packed {
      logic signed [4:0] row_off;
      logic signed [4:0] col_off;
      logic [21:0]       sad;
   } match_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   // shadow state of the block
   logic [23:0] cur_pix [4096];
   logic [23:0] ref_pix [4096];
   bit          cur_ok  [4096];
   bit          ref_ok  [4096];
   int          cfg_rows, cfg_cols, cfg_block, cfg_range;

   match_type   pending_matches[$];
   int          mismatches;
   int          idle_cycles;
   int          words_sent;
   bit          idle_on;
   bit          hold_rsp;

   full_search_block_motion_estimator_top uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // best offset and SAD over the whole search window
   function automatic match_type predict_match(int org_r, int org_c);
      int rows, cols, rng, dr, dc, x, y, cr, cc, rr, rc, k, a, b;
      int unsigned sum, best;
      bit have;
      match_type m;
      rows = cfg_rows > 64 ? 64 : cfg_rows;
      cols = cfg_cols > 64 ? 64 : cfg_cols;
      rng  = cfg_range;
      have = 0;
      best = 0;
      m = '0;
      for (dr = -rng; dr <= rng; dr++) begin
         for (dc = -rng; dc <= rng; dc++) begin
            sum = 0;
            for (x = 0; x < cfg_block; x++) begin
               cr = org_r + x;
               rr = cr + dr;
               if (cr >= rows || rr < 0 || rr >= rows) continue;
               for (y = 0; y < cfg_block; y++) begin
                  cc = org_c + y;
                  rc = cc + dc;
                  if (cc >= cols || rc < 0 || rc >= cols) continue;
                  for (k = 0; k < 3; k++) begin
                     a = cur_pix[cr*STORE_COLS+cc][8*k +: 8];
                     b = ref_pix[rr*STORE_COLS+rc][8*k +: 8];
                     sum += (a > b) ? a - b : b - a;
                  end
               end
            end
            if (!have || sum < best) begin
               have = 1;
               best = sum;
               m.row_off = dr[4:0];
               m.col_off = dc[4:0];
            end
         end
      end
      m.sad = (best > fsme_pkg::SAD_MAX) ? fsme_pkg::SAD_MAX : best[21:0];
      return m;
   endfunction

   // send one word; called and returns at a falling edge
   task automatic send_word(logic [1:0] cmd, int r, int c, logic [23:0] rgb);
      int p;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = {4'b0, rgb[7:0], rgb[15:8], rgb[23:16], c[5:0], r[5:0]};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      p = r[5:0] * STORE_COLS + c[5:0];
      case (cmd)
         fsme_pkg::CMD_LOAD_CUR: begin
            cur_pix[p] = rgb;
            cur_ok[p]  = 1;
         end
         fsme_pkg::CMD_LOAD_REF: begin
            ref_pix[p] = rgb;
            ref_ok[p]  = 1;
         end
         fsme_pkg::CMD_SEARCH:
            pending_matches = {pending_matches, predict_match(r[5:0], c[5:0])};
         default: ;
      endcase
      words_sent++;
      @(negedge clock);
   endtask

   // load every pixel a search at this origin can touch that is still unwritten
   task automatic fill_window(int org_r, int org_c);
      int rows, cols, r, c;
      rows = cfg_rows > 64 ? 64 : cfg_rows;
      cols = cfg_cols > 64 ? 64 : cfg_cols;
      for (r = org_r; r < org_r + cfg_block && r < rows; r++)
         for (c = org_c; c < org_c + cfg_block && c < cols; c++)
            if (!cur_ok[r*STORE_COLS+c])
               send_word(fsme_pkg::CMD_LOAD_CUR, r, c, 24'($urandom));
      for (r = org_r - cfg_range; r < org_r + cfg_block + cfg_range && r < rows; r++)
         for (c = org_c - cfg_range; c < org_c + cfg_block + cfg_range && c < cols; c++)
            if (r >= 0 && c >= 0 && !ref_ok[r*STORE_COLS+c])
               send_word(fsme_pkg::CMD_LOAD_REF, r, c, 24'($urandom));
   endtask

   task automatic search_at(int r, int c);
      fill_window(r, c);
      send_word(fsme_pkg::CMD_SEARCH, r, c, 24'($urandom));
   endtask

   // stop sending, let all results come back and the block settle
   task automatic wait_idle();
      req_tvalid = 0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // APB write: setup then access phase
   task automatic write_reg(logic [1:0] idx, int val);
      csr_psel    = 1;
      csr_penable = 0;
      csr_pwrite  = 1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
      case (idx)
         fsme_pkg::REG_ROWS:  cfg_rows  = val & 'h7F;
         fsme_pkg::REG_COLS:  cfg_cols  = val & 'h7F;
         fsme_pkg::REG_BLOCK: cfg_block = val & 'h7F;
         default:             cfg_range = val & 'hF;
      endcase
   endtask

   task automatic set_config(int rows, int cols, int blk, int rng);
      wait_idle();
      write_reg(fsme_pkg::REG_ROWS, rows);
      write_reg(fsme_pkg::REG_COLS, cols);
      write_reg(fsme_pkg::REG_BLOCK, blk);
      write_reg(fsme_pkg::REG_RANGE, rng);
   endtask

   // ignored command, channel extremes, tiny frame searches
   task automatic test_basic();
      send_word(fsme_pkg::CMD_UNUSED, 63, 63, 24'hFFFFFF);
      send_word(fsme_pkg::CMD_LOAD_CUR, 63, 63, 24'hFFFFFF);
      send_word(fsme_pkg::CMD_LOAD_REF, 63, 63, 24'h000000);
      set_config(2, 2, 2, 1);
      send_word(fsme_pkg::CMD_LOAD_CUR, 0, 0, 24'hFFFFFF);
      send_word(fsme_pkg::CMD_LOAD_REF, 0, 1, 24'hFFFFFF);
      search_at(0, 0);
      search_at(1, 1);
   endtask

   // zero sizes, oversized frame and block, widest range
   task automatic test_extremes();
      set_config(0, 64, 8, 7);
      send_word(fsme_pkg::CMD_SEARCH, 0, 0, '0);
      set_config(4, 4, 0, 2);
      send_word(fsme_pkg::CMD_SEARCH, 1, 1, '0);
      set_config(127, 127, 2, 1);
      search_at(62, 62);
      search_at(63, 0);
      set_config(4, 4, 1, 15);
      search_at(3, 3);
      set_config(1, 1, 64, 0);
      search_at(0, 0);
      set_config(4, 4, 127, 0);
      search_at(0, 0);
      set_config(64, 64, 8, 0);
      search_at(56, 56);
   endtask

   // long receiver stall while searches keep coming, then a full drain
   task automatic test_backpressure();
      set_config(8, 8, 2, 1);
      hold_rsp = 1;
      repeat (5) search_at($urandom_range(0, 7), $urandom_range(0, 7));
      wait_idle();
      search_at(0, 0);
   endtask

   task automatic test_random();
      int ph, target, sel;
      for (ph = 0; ph < 5; ph++) begin
         idle_on = (ph != 4);
         set_config($urandom_range(0, 4) == 0 ? 64 : $urandom_range(1, 64),
                    $urandom_range(0, 4) == 0 ? 64 : $urandom_range(1, 64),
                    $urandom_range(1, 6), $urandom_range(0, 3));
         target = words_sent + 150;
         while (words_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
               send_word(fsme_pkg::CMD_UNUSED, $urandom_range(0, 63),
                         $urandom_range(0, 63), 24'($urandom));
            else if (sel < 75)
               send_word(sel[0] ? fsme_pkg::CMD_LOAD_REF : fsme_pkg::CMD_LOAD_CUR,
                         $urandom_range(0, 63), $urandom_range(0, 63), 24'($urandom));
            else
               search_at($urandom_range(0, 63), $urandom_range(0, 63));
         end
      end
   endtask

   // result check against the oldest expected match
   always @(posedge clock) begin
      match_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[4:0], rsp_tdata[9:5], rsp_tdata[31:10]};
         if (pending_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = pending_matches.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("match mismatch: want row %0d col %0d sad %0d, got row %0d col %0d sad %0d",
                           want.row_off, want.col_off, want.sad,
                           got.row_off, got.col_off, got.sad);
            end
         end
      end
   end

   // result-side ready with random stalls and one long hold
   initial begin
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 0;
            repeat (1500) @(negedge clock);
            hold_rsp = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_tready = 1;
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_cycles = 0;
      mismatches  = 0;
      words_sent  = 0;
      idle_on     = 1;
      hold_rsp    = 0;
      cfg_rows    = 64;
      cfg_cols    = 64;
      cfg_block   = 8;
      cfg_range   = 7;
      foreach (cur_ok[i]) begin
         cur_ok[i] = 0;
         ref_ok[i] = 0;
      end
      repeat (8) @(negedge clock);
      reset = 0;
      @(negedge clock);

      test_basic();
      test_extremes();
      test_backpressure();
      test_random();

      wait_idle();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
